// ----- sv/adc_bs_pkg.sv -----
// Package with constants and types for the ADC burst statistics unit.
package adc_bs_pkg;

	localparam int MAX_SAMPLES     = 32;
	localparam int DEFAULT_SAMPLES = 8;
	localparam int SAMPLE_BITS     = 12;
	localparam int ADDR_BITS       = 5;
	localparam int CNT_BITS        = 6;
	localparam int LEN_BITS        = 8;
	localparam int SUM_BITS        = 17;
	localparam int SQ_BITS         = 30;
	localparam int DEV_BITS        = 11;
	localparam int ROOT_BITS       = 15;
	localparam int REM_BITS        = 17;

	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(8);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_DIVM  = 10'b00_0000_0010,
		ST_MUL1  = 10'b00_0000_0100,
		ST_MUL2  = 10'b00_0000_1000,
		ST_VAR   = 10'b00_0001_0000,
		ST_DIVV  = 10'b00_0010_0000,
		ST_SQRT  = 10'b00_0100_0000,
		ST_MEDA  = 10'b00_1000_0000,
		ST_MEDJ  = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

endpackage

// ----- sv/adc_burst_statistics_unit.sv -----
// Top level of the ADC burst statistics unit: sample store, accumulators and sequencer.
// Each sample is a one-cycle transfer; busy stays low between samples of a burst.
// The closing sample holds busy high through a 30-step shared divider for mean and
// variance, the product states MUL1, MUL2 and VAR, a 15-step root, a rank scan per
// sample with one memory read per cycle, and a final output state.
// The result shows for one cycle on done as busy falls; the receiver cannot stall it.
// Reset clears accumulators, sequencer and burst length (to 8); store content is undefined.
module adc_burst_statistics_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [adc_bs_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic                                cfg_we,
	input  logic [adc_bs_pkg::LEN_BITS-1:0]     cfg_wdata,
	output logic                                done,
	output logic [adc_bs_pkg::SAMPLE_BITS-1:0]  minimum,
	output logic [adc_bs_pkg::SAMPLE_BITS-1:0]  maximum,
	output logic [adc_bs_pkg::SAMPLE_BITS-1:0]  average,
	output logic [adc_bs_pkg::SAMPLE_BITS-1:0]  middle_value,
	output logic [adc_bs_pkg::DEV_BITS-1:0]     deviation,
	output logic [adc_bs_pkg::CNT_BITS-1:0]     sample_count
);
	import adc_bs_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [ADDR_BITS-1:0]   rd_addr;

	state_t                 state_q;
	logic [LEN_BITS-1:0]    len_q;
	logic [CNT_BITS-1:0]    fill_q, n_q, i_q, j_q, cl_q, cle_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SQ_BITS-1:0]     sq_q;
	logic [SAMPLE_BITS-1:0] min_q, max_q, mean_q, xi_q, lo_q, hi_q;
	logic [23:0]            msq_q;
	logic [28:0]            ms_q;
	logic [SQ_BITS-1:0]     nsq_q;
	logic [SQ_BITS-1:0]     dq_q;
	logic [CNT_BITS-1:0]    rem_q;
	logic [4:0]             step_q;
	logic [REM_BITS-1:0]    srem_q;
	logic [ROOT_BITS-1:0]   root_q;

	logic                   accept, closing;
	logic [CNT_BITS-1:0]    eff_len, fill_next, cl_n, cle_n, k0, k1;
	logic [CNT_BITS:0]      dtrial;
	logic [REM_BITS-1:0]    strial_rem, strial;
	logic [31:0]            var_full;
	logic [SAMPLE_BITS:0]   med_sum;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign fill_next = fill_q + CNT_BITS'(1);
	assign eff_len   = (len_q == '0 || len_q > LEN_BITS'(MAX_SAMPLES))
		? CNT_BITS'(DEFAULT_SAMPLES) : len_q[CNT_BITS-1:0];
	assign closing   = fill_next >= eff_len;

	// divider step: bring down the next dividend bit
	assign dtrial     = {rem_q, dq_q[SQ_BITS-1]};
	// root step: bring down the next bit pair
	assign strial_rem = {srem_q[REM_BITS-3:0], dq_q[SQ_BITS-1:SQ_BITS-2]};
	assign strial     = {root_q, 2'b01};

	assign var_full = 32'(sq_q) + 32'(nsq_q) - {2'b00, ms_q, 1'b0};

	assign cl_n  = cl_q + CNT_BITS'(rd_q < xi_q);
	assign cle_n = cle_q + CNT_BITS'(rd_q <= xi_q);
	assign k0    = (n_q - CNT_BITS'(1)) >> 1;
	assign k1    = n_q >> 1;
	assign med_sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		rd_addr = i_q[ADDR_BITS-1:0];
		if (state_q == ST_MEDJ) begin
			if (j_q == n_q - CNT_BITS'(1)) begin
				rd_addr = i_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
			end else begin
				rd_addr = j_q[ADDR_BITS-1:0] + ADDR_BITS'(1);
			end
		end else if (state_q == ST_MEDA || state_q == ST_SQRT) begin
			rd_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[fill_q[ADDR_BITS-1:0]] <= sample;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= LEN_RESET;
			fill_q  <= '0;
			sum_q   <= '0;
			sq_q    <= '0;
			min_q   <= '1;
			max_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_next;
						sum_q  <= sum_q + SUM_BITS'(sample);
						sq_q   <= sq_q + SQ_BITS'(24'(sample) * 24'(sample));
						if (sample < min_q) min_q <= sample;
						if (sample > max_q) max_q <= sample;
						if (closing) begin
							n_q     <= fill_next;
							dq_q    <= SQ_BITS'(sum_q + SUM_BITS'(sample));
							rem_q   <= '0;
							step_q  <= 5'(SQ_BITS - 1);
							state_q <= ST_DIVM;
						end
					end
				end
				ST_DIVM, ST_DIVV: begin
					if (dtrial >= {1'b0, n_q}) begin
						rem_q <= CNT_BITS'(dtrial - {1'b0, n_q});
						dq_q  <= {dq_q[SQ_BITS-2:0], 1'b1};
					end else begin
						rem_q <= dtrial[CNT_BITS-1:0];
						dq_q  <= {dq_q[SQ_BITS-2:0], 1'b0};
					end
					step_q <= step_q - 5'd1;
					if (step_q == '0) begin
						if (state_q == ST_DIVM) begin
							state_q <= ST_MUL1;
						end else begin
							srem_q  <= '0;
							root_q  <= '0;
							step_q  <= 5'(ROOT_BITS - 1);
							state_q <= ST_SQRT;
						end
					end
				end
				ST_MUL1: begin
					mean_q  <= dq_q[SAMPLE_BITS-1:0];
					msq_q   <= dq_q[SAMPLE_BITS-1:0] * dq_q[SAMPLE_BITS-1:0];
					ms_q    <= dq_q[SAMPLE_BITS-1:0] * sum_q;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					nsq_q   <= SQ_BITS'(n_q) * SQ_BITS'(msq_q);
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					dq_q    <= var_full[SQ_BITS-1:0];
					rem_q   <= '0;
					step_q  <= 5'(SQ_BITS - 1);
					state_q <= ST_DIVV;
				end
				ST_SQRT: begin
					if (strial_rem >= strial) begin
						srem_q <= strial_rem - strial;
						root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
					end else begin
						srem_q <= strial_rem;
						root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
					end
					dq_q   <= {dq_q[SQ_BITS-3:0], 2'b00};
					step_q <= step_q - 5'd1;
					if (step_q == '0) begin
						i_q     <= '0;
						state_q <= ST_MEDA;
					end
				end
				ST_MEDA: begin
					// rd_q holds x_i; start the scan at entry zero
					xi_q    <= rd_q;
					j_q     <= '0;
					cl_q    <= '0;
					cle_q   <= '0;
					state_q <= ST_MEDJ;
				end
				ST_MEDJ: begin
					cl_q  <= cl_n;
					cle_q <= cle_n;
					j_q   <= j_q + CNT_BITS'(1);
					if (j_q == n_q - CNT_BITS'(1)) begin
						if (cl_n <= k0 && k0 < cle_n) lo_q <= xi_q;
						if (cl_n <= k1 && k1 < cle_n) hi_q <= xi_q;
						i_q <= i_q + CNT_BITS'(1);
						if (i_q == n_q - CNT_BITS'(1)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MEDA;
						end
					end
				end
				ST_DONE: begin
					minimum      <= min_q;
					maximum      <= max_q;
					average      <= mean_q;
					middle_value <= med_sum[SAMPLE_BITS:1];
					deviation    <= root_q[DEV_BITS-1:0];
					sample_count <= n_q;
					done         <= 1'b1;
					fill_q       <= '0;
					sum_q        <= '0;
					sq_q         <= '0;
					min_q        <= '1;
					max_q        <= '0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
